### rtl/lru_pkg.sv
package lru_pkg;

	// Frame store geometry
	localparam int FRAMES      = 8;
	localparam int PAGE_BITS   = 16;
	localparam int FRAME_W     = $clog2(FRAMES);
	localparam int RANK_W      = $clog2(FRAMES);
	localparam int FRAME_CNT_W = $clog2(FRAMES + 1);

	// Result field widths
	localparam int OUT_PAGE_W  = 16;
	localparam int FAULT_W     = 16;
	localparam int CFG_W       = 4;

	localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
	localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [RANK_W-1:0]    rank_t;
	typedef logic [FRAME_W-1:0]   frame_idx_t;

endpackage

### rtl/lru_req_if.sv
interface lru_req_if;
	logic        valid;
	logic        ready;
	logic [15:0] page_number;
	logic        last_reference;

	modport source (output valid, output page_number, output last_reference, input ready);
	modport sink   (input valid, input page_number, input last_reference, output ready);
endinterface

### rtl/lru_rsp_if.sv
interface lru_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [2:0]  frame_index;
	logic        evicted_valid;
	logic [15:0] evicted_page;
	logic [15:0] fault_total;
	logic        run_done;

	modport source (output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_total, output run_done, input ready);
	modport sink   (input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_total, input run_done, output ready);
endinterface

### rtl/lru_page_replacement_unit.sv
// LRU page replacement unit. Each page reference beat on req yields one result beat on
// rsp: hit or miss, the frame that holds the page afterwards, the page evicted (if any)
// and the running fault count of the run. A miss fills the lowest empty frame among the
// first frames_in_use frames, else replaces the least recently used one of them. A beat
// with last_reference set closes the run: its result carries the final fault count and
// all frame state clears, while frames_in_use is kept. One reference is taken every
// cycle unless rsp.ready stalls the result; a beat passes an input register, then the
// frame lookup and recency update into the result register. frames_in_use of 0 acts
// as 1 and values above 8 act as 8; write it only while the unit is idle.
module lru_page_replacement_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [3:0]  cfg_wr_data,
	lru_req_if.sink     req,
	lru_rsp_if.source   rsp
);

	localparam int FR = lru_pkg::FRAMES;

	// Configuration
	logic [lru_pkg::CFG_W-1:0] frames_in_use_q;

	// Input stage
	logic                valid_s1;
	lru_pkg::page_t      page_s1;
	logic                last_s1;

	// Result stage
	logic                valid_s2;
	logic                hit_s2;
	logic [2:0]          frame_index_s2;
	logic                evicted_valid_s2;
	logic [15:0]         evicted_page_s2;
	logic [15:0]         fault_total_s2;
	logic                run_done_s2;

	// Frame state
	lru_pkg::page_t      frame_page_q  [FR];
	logic [FR-1:0]       frame_valid_q;
	lru_pkg::rank_t      recency_rank_q [FR];
	logic [lru_pkg::FAULT_W-1:0] fault_count_q;

	// Lookup results
	logic [lru_pkg::FRAME_CNT_W-1:0] n_eff;
	logic [FR-1:0]       hit_vec;
	logic [FR-1:0]       empty_vec;
	logic                any_hit;
	logic                any_empty;
	lru_pkg::frame_idx_t hit_idx;
	lru_pkg::frame_idx_t empty_idx;
	lru_pkg::frame_idx_t victim_idx;
	lru_pkg::rank_t      victim_rank;
	logic                victim_have;
	lru_pkg::frame_idx_t sel_idx;
	logic [lru_pkg::RANK_W:0] old_rank;
	lru_pkg::rank_t      rank_nxt [FR];
	logic [lru_pkg::FAULT_W-1:0] fault_nxt;

	logic advance;

	// Handshake: hold the result until taken; take a new beat only while the input stage is empty or advancing
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Clamp the frame count to one through FRAMES
	always_comb begin
		if (frames_in_use_q == '0) begin
			n_eff = lru_pkg::FRAME_CNT_W'(1);
		end else if (lru_pkg::FRAME_CNT_W'(frames_in_use_q) > lru_pkg::FRAME_CNT_W'(FR)) begin
			n_eff = lru_pkg::FRAME_CNT_W'(FR);
		end else begin
			n_eff = lru_pkg::FRAME_CNT_W'(frames_in_use_q);
		end
	end

	// Compare all frames in parallel; lowest index wins
	always_comb begin
		for (int i = 0; i < FR; i++) begin
			hit_vec[i]   = (lru_pkg::FRAME_CNT_W'(i) < n_eff) && frame_valid_q[i]
				&& (frame_page_q[i] == page_s1);
			empty_vec[i] = (lru_pkg::FRAME_CNT_W'(i) < n_eff) && !frame_valid_q[i];
		end
		any_hit   = |hit_vec;
		any_empty = |empty_vec;
		hit_idx   = '0;
		empty_idx = '0;
		for (int i = FR - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_idx = lru_pkg::FRAME_W'(i);
			end
			if (empty_vec[i]) begin
				empty_idx = lru_pkg::FRAME_W'(i);
			end
		end
	end

	// Pick the oldest frame among those taking part
	always_comb begin
		victim_idx  = '0;
		victim_rank = '0;
		victim_have = 1'b0;
		for (int i = 0; i < FR; i++) begin
			if ((lru_pkg::FRAME_CNT_W'(i) < n_eff) && frame_valid_q[i]
					&& (!victim_have || recency_rank_q[i] > victim_rank)) begin
				victim_idx  = lru_pkg::FRAME_W'(i);
				victim_rank = recency_rank_q[i];
				victim_have = 1'b1;
			end
		end
	end

	// Choose the frame and the rank it leaves behind
	always_comb begin
		if (any_hit) begin
			sel_idx  = hit_idx;
			old_rank = {1'b0, recency_rank_q[hit_idx]};
		end else if (any_empty) begin
			sel_idx  = empty_idx;
			old_rank = (lru_pkg::RANK_W+1)'(FR);
		end else begin
			sel_idx  = victim_idx;
			old_rank = {1'b0, victim_rank};
		end
	end

	// Age the frames that were more recent than the chosen one
	always_comb begin
		for (int i = 0; i < FR; i++) begin
			if (lru_pkg::FRAME_W'(i) == sel_idx) begin
				rank_nxt[i] = '0;
			end else if (frame_valid_q[i] && ({1'b0, recency_rank_q[i]} < old_rank)) begin
				rank_nxt[i] = recency_rank_q[i] + lru_pkg::RANK_W'(1);
			end else begin
				rank_nxt[i] = recency_rank_q[i];
			end
		end
	end

	// Count the fault, saturating
	always_comb begin
		if (!any_hit && fault_count_q != lru_pkg::FAULT_MAX) begin
			fault_nxt = fault_count_q + lru_pkg::FAULT_W'(1);
		end else begin
			fault_nxt = fault_count_q;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lru_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			frames_in_use_q <= cfg_wr_data;
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			page_s1 <= lru_pkg::PAGE_BITS'(req.page_number);
			last_s1 <= req.last_reference;
		end
	end

	// Result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s2           <= any_hit;
			frame_index_s2   <= 3'(sel_idx);
			evicted_valid_s2 <= !any_hit && !any_empty;
			evicted_page_s2  <= (!any_hit && !any_empty)
				? 16'(frame_page_q[victim_idx]) : '0;
			fault_total_s2   <= 16'(fault_nxt);
			run_done_s2      <= last_s1;
		end
	end

	// Frame valid bits, ranks and fault count; clear at the end of a run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_q <= '0;
			fault_count_q <= '0;
			for (int i = 0; i < FR; i++) begin
				recency_rank_q[i] <= '0;
			end
		end else if (advance) begin
			if (last_s1) begin
				frame_valid_q <= '0;
				fault_count_q <= '0;
				for (int i = 0; i < FR; i++) begin
					recency_rank_q[i] <= '0;
				end
			end else begin
				frame_valid_q[sel_idx] <= 1'b1;
				fault_count_q          <= fault_nxt;
				for (int i = 0; i < FR; i++) begin
					recency_rank_q[i] <= rank_nxt[i];
				end
			end
		end
	end

	// Load the page into the chosen frame on a miss
	always_ff @(posedge clk) begin
		if (advance && !any_hit) begin
			frame_page_q[sel_idx] <= page_s1;
		end
	end

	// Drive the result channel
	assign rsp.valid         = valid_s2;
	assign rsp.hit           = hit_s2;
	assign rsp.frame_index   = frame_index_s2;
	assign rsp.evicted_valid = evicted_valid_s2;
	assign rsp.evicted_page  = evicted_page_s2;
	assign rsp.fault_total   = fault_total_s2;
	assign rsp.run_done      = run_done_s2;

endmodule
